@@ rtl/vrp_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// vrp_pkg
// Shared types, widths and constants of the vertex rotate and project block.
// ============================================================================
package vrp_pkg;

  // Field and register widths.
  localparam int VtxW     = 24;
  localparam int TrigW    = 16;
  localparam int ScaleW   = 24;
  localparam int RegIdxW  = 3;
  localparam int CfgDataW = 24;
  localparam int PixW     = 16;
  localparam int DepthW   = 24;

  // Internal widths of the transform path.
  localparam int X1W  = 27;   // x after the Z rotation
  localparam int Y1W  = 27;   // y after the Z rotation
  localparam int Y2W  = 30;   // y after the X rotation
  localparam int WW   = 31;   // z after the X rotation plus 3.0
  localparam int PXW  = 35;   // projected x before the divide
  localparam int PYW  = 38;   // projected y before the divide
  localparam int PZW  = 40;   // projected depth before the divide
  localparam int NumW = 56;   // dividend magnitude (value times 2^16)
  localparam int DivW = 31;   // divisor magnitude
  localparam int QuoW = 42;   // quotient magnitude bits kept by the divider

  // Default screen size.
  localparam int DefScreenWidth  = 256;
  localparam int DefScreenHeight = 240;

  // 3.0 in Q.16, and the divisor used when w is zero (divide by 1.0).
  localparam int ZBias     = 196608;
  localparam int UnitDiv   = 65536;

  // Screen mapping: pixel = (p + 10.0) * size / (20 * 2^16).
  localparam int PixBias    = 655360;
  localparam int PixShift   = 18;       // 20 * 2^16 = 5 * 2^18
  localparam int PixMagMax  = 163845;   // 5 * 32769, saturates every size
  localparam int Recip5     = 52429;    // ceil(2^18 / 5)
  localparam int Recip5W    = 16;
  localparam int PixMW      = 18;

  // Clamp bound of projected x and y, and depth limits.
  localparam logic [QuoW-1:0] PixClamp = QuoW'(1) << 40;
  localparam logic [QuoW-1:0] DepthPosLim = QuoW'(8388607);
  localparam logic [QuoW-1:0] DepthNegLim = QuoW'(8388608);
  localparam logic [DepthW-1:0] DepthMax = 24'h7FFFFF;
  localparam logic [DepthW-1:0] DepthMin = 24'h800000;
  localparam logic [PixW-1:0] PixMax = 16'h7FFF;
  localparam logic [PixW-1:0] PixMin = 16'h8000;

  // Register index map.
  typedef enum logic [RegIdxW-1:0] {
    REG_ROT_Z_COS    = 3'd0,
    REG_ROT_Z_SIN    = 3'd1,
    REG_ROT_X_COS    = 3'd2,
    REG_ROT_X_SIN    = 3'd3,
    REG_PROJ_X_SCALE = 3'd4,
    REG_PROJ_Y_SCALE = 3'd5,
    REG_DEPTH_SCALE  = 3'd6,
    REG_DEPTH_OFFSET = 3'd7
  } vrp_reg_e;

  // Configuration register file.
  typedef struct packed {
    logic signed [TrigW-1:0]  rot_z_cos;
    logic signed [TrigW-1:0]  rot_z_sin;
    logic signed [TrigW-1:0]  rot_x_cos;
    logic signed [TrigW-1:0]  rot_x_sin;
    logic signed [ScaleW-1:0] proj_x_scale;
    logic signed [ScaleW-1:0] proj_y_scale;
    logic signed [ScaleW-1:0] depth_scale;
    logic signed [ScaleW-1:0] depth_offset;
  } vrp_cfg_t;

  // Control that travels with an item through the front stages.
  typedef struct packed {
    logic valid;
    logic last;
  } vrp_ctrl_t;

  // Control that travels with an item through the divider.
  typedef struct packed {
    logic valid;
    logic last;
    logic skip;
    logic neg;
  } vrp_tag_t;

  // One finished result.
  typedef struct packed {
    logic              last;
    logic              skip;
    logic [DepthW-1:0] depth;
    logic [PixW-1:0]   screen_y;
    logic [PixW-1:0]   screen_x;
  } vrp_result_t;

endpackage

@@ rtl/vrp_rotate.sv @@
`timescale 1ns / 1ps
// ============================================================================
// vrp_rotate
// Four stages: rotation about Z, then about X, then the 3.0 offset on z.
// ============================================================================
module vrp_rotate (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  vrp_pkg::vrp_cfg_t               cfg_i,
  input  vrp_pkg::vrp_ctrl_t              ctrl_i,
  input  logic signed [vrp_pkg::VtxW-1:0] vx_i,
  input  logic signed [vrp_pkg::VtxW-1:0] vy_i,
  input  logic signed [vrp_pkg::VtxW-1:0] vz_i,
  output vrp_pkg::vrp_ctrl_t              ctrl_o,
  output logic signed [vrp_pkg::X1W-1:0]  x1_o,
  output logic signed [vrp_pkg::Y2W-1:0]  y2_o,
  output logic signed [vrp_pkg::WW-1:0]   w_o
);
  import vrp_pkg::*;

  localparam int P1W = VtxW + TrigW;   // Z rotation products
  localparam int P3W = Y1W + TrigW;    // X rotation products of y1

  vrp_ctrl_t c1_q, c2_q, c3_q, c4_q;

  logic signed [P1W-1:0] xzc_q, yzs_q, xzs_q, yzc_q;
  logic signed [VtxW-1:0] z1_q, z2_q;
  logic signed [X1W-1:0] x1a_q, x1b_q, x1c_q;
  logic signed [Y1W-1:0] y1_q;
  logic signed [P3W-1:0] yxc_q, yxs_q;
  logic signed [P1W-1:0] zxs_q, zxc_q;
  logic signed [Y2W-1:0] y2_q;
  logic signed [WW-1:0]  w_q;

  logic signed [P1W:0]   xsum, ysum;
  logic signed [P3W:0]   y2sum, z2sum;
  logic signed [Y2W-1:0] z2;

  // Valid bits of the four stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
    end else if (en_i) begin
      c1_q <= ctrl_i;
      c2_q <= c1_q;
      c3_q <= c2_q;
      c4_q <= c3_q;
    end
  end

  // Sums of the rotation products, shifted by 14 (floor).
  always_comb begin
    xsum  = (P1W+1)'(xzc_q) - (P1W+1)'(yzs_q);
    ysum  = (P1W+1)'(xzs_q) + (P1W+1)'(yzc_q);
    y2sum = (P3W+1)'(yxc_q) - (P3W+1)'(zxs_q);
    z2sum = (P3W+1)'(yxs_q) + (P3W+1)'(zxc_q);
    z2    = $signed(z2sum[P3W:14]);
  end

  // Data stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Stage 1: Z rotation products.
      xzc_q <= vx_i * $signed(cfg_i.rot_z_cos);
      yzs_q <= vy_i * $signed(cfg_i.rot_z_sin);
      xzs_q <= vx_i * $signed(cfg_i.rot_z_sin);
      yzc_q <= vy_i * $signed(cfg_i.rot_z_cos);
      z1_q  <= vz_i;
      // Stage 2: rotated x and y.
      x1a_q <= $signed(xsum[P1W:14]);
      y1_q  <= $signed(ysum[P1W:14]);
      z2_q  <= z1_q;
      // Stage 3: X rotation products.
      yxc_q <= y1_q * $signed(cfg_i.rot_x_cos);
      yxs_q <= y1_q * $signed(cfg_i.rot_x_sin);
      zxs_q <= z2_q * $signed(cfg_i.rot_x_sin);
      zxc_q <= z2_q * $signed(cfg_i.rot_x_cos);
      x1b_q <= x1a_q;
      // Stage 4: rotated y and translated z.
      y2_q  <= $signed(y2sum[P3W:14]);
      w_q   <= WW'(z2) + WW'(ZBias);
      x1c_q <= x1b_q;
    end
  end

  assign ctrl_o = c4_q;
  assign x1_o   = x1c_q;
  assign y2_o   = y2_q;
  assign w_o    = w_q;

endmodule

@@ rtl/vrp_project.sv @@
`timescale 1ns / 1ps
// ============================================================================
// vrp_project
// Three stages: projection products, depth offset, and the sign and
// magnitude split that feeds the dividers.
// ============================================================================
module vrp_project (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  vrp_pkg::vrp_cfg_t               cfg_i,
  input  vrp_pkg::vrp_ctrl_t              ctrl_i,
  input  logic signed [vrp_pkg::X1W-1:0]  x1_i,
  input  logic signed [vrp_pkg::Y2W-1:0]  y2_i,
  input  logic signed [vrp_pkg::WW-1:0]   w_i,
  output vrp_pkg::vrp_tag_t               tag_x_o,
  output vrp_pkg::vrp_tag_t               tag_y_o,
  output vrp_pkg::vrp_tag_t               tag_z_o,
  output logic [vrp_pkg::NumW-1:0]        num_x_o,
  output logic [vrp_pkg::NumW-1:0]        num_y_o,
  output logic [vrp_pkg::NumW-1:0]        num_z_o,
  output logic [vrp_pkg::DivW-1:0]        div_o
);
  import vrp_pkg::*;

  localparam int MXW = X1W + ScaleW;
  localparam int MYW = Y2W + ScaleW;
  localparam int MZW = WW + ScaleW;

  vrp_ctrl_t c5_q, c6_q;
  logic      v7_q, l7_q;

  logic signed [MXW-1:0] mx_q;
  logic signed [MYW-1:0] my_q;
  logic signed [MZW-1:0] mz_q;
  logic signed [WW-1:0]  w5_q, w6_q;
  logic signed [PXW-1:0] px_q;
  logic signed [PYW-1:0] py_q;
  logic signed [PZW-1:0] pz_q;
  logic                  skip6_q, skip7_q;
  logic                  nx_q, ny_q, nz_q;
  logic [NumW-1:0]       numx_q, numy_q, numz_q;
  logic [DivW-1:0]       div_q;

  logic [PXW-1:0] pxm;
  logic [PYW-1:0] pym;
  logic [PZW-1:0] pzm;
  logic [DivW-1:0] wm;

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c5_q <= '0;
      c6_q <= '0;
      v7_q <= 1'b0;
    end else if (en_i) begin
      c5_q <= ctrl_i;
      c6_q <= c5_q;
      v7_q <= c6_q.valid;
    end
  end

  // Magnitudes of the projected values and of w.
  always_comb begin
    pxm = px_q[PXW-1] ? PXW'(-px_q) : PXW'(px_q);
    pym = py_q[PYW-1] ? PYW'(-py_q) : PYW'(py_q);
    pzm = pz_q[PZW-1] ? PZW'(-pz_q) : PZW'(pz_q);
    wm  = w6_q[WW-1] ? DivW'(-w6_q) : DivW'(w6_q);
  end

  // Data stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Stage 5: projection products.
      mx_q <= x1_i * $signed(cfg_i.proj_x_scale);
      my_q <= y2_i * $signed(cfg_i.proj_y_scale);
      mz_q <= w_i * $signed(cfg_i.depth_scale);
      w5_q <= w_i;
      // Stage 6: shift by 16 (floor) and add the depth offset.
      px_q    <= $signed(mx_q[MXW-1:16]);
      py_q    <= $signed(my_q[MYW-1:16]);
      pz_q    <= PZW'($signed(mz_q[MZW-1:16])) + PZW'($signed(cfg_i.depth_offset));
      w6_q    <= w5_q;
      skip6_q <= (w5_q == '0);
      // Stage 7: dividend magnitudes (value times 2^16), divisor and signs.
      // A zero w divides by 1.0 so the value passes unchanged.
      numx_q  <= NumW'({pxm, 16'h0000});
      numy_q  <= NumW'({pym, 16'h0000});
      numz_q  <= NumW'({pzm, 16'h0000});
      div_q   <= skip6_q ? DivW'(UnitDiv) : wm;
      nx_q    <= px_q[PXW-1] ^ w6_q[WW-1];
      ny_q    <= py_q[PYW-1] ^ w6_q[WW-1];
      nz_q    <= pz_q[PZW-1] ^ w6_q[WW-1];
      skip7_q <= skip6_q;
      l7_q    <= c6_q.last;
    end
  end

  assign tag_x_o = '{valid: v7_q, last: l7_q, skip: skip7_q, neg: nx_q};
  assign tag_y_o = '{valid: v7_q, last: l7_q, skip: skip7_q, neg: ny_q};
  assign tag_z_o = '{valid: v7_q, last: l7_q, skip: skip7_q, neg: nz_q};
  assign num_x_o = numx_q;
  assign num_y_o = numy_q;
  assign num_z_o = numz_q;
  assign div_o   = div_q;

endmodule

@@ rtl/vrp_div.sv @@
`timescale 1ns / 1ps
// ============================================================================
// vrp_div
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag for quotients that do not fit in QuoW bits.
// ============================================================================
module vrp_div #(
  parameter int NumW = vrp_pkg::NumW,
  parameter int DivW = vrp_pkg::DivW,
  parameter int QuoW = vrp_pkg::QuoW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  vrp_pkg::vrp_tag_t   tag_i,
  input  logic [NumW-1:0]     num_i,
  input  logic [DivW-1:0]     div_i,
  output vrp_pkg::vrp_tag_t   tag_o,
  output logic [QuoW-1:0]     quo_o,
  output logic                ovf_o
);
  import vrp_pkg::*;

  localparam int HiW  = NumW - QuoW;
  localparam int CmpW = (HiW > DivW) ? HiW : DivW;
  localparam int AccW = DivW + QuoW;

  // Per stage: partial remainder over the dividend bits still to come,
  // which are replaced one by one by quotient bits.
  logic [AccW-1:0] acc_q [QuoW+1];
  logic [DivW-1:0] div_q [QuoW+1];
  logic            ovf_q [QuoW+1];
  vrp_tag_t        tag_q [QuoW+1];

  logic [HiW-1:0]  hi;
  logic            ovf0;

  // Entry: the quotient overflows when the top dividend bits reach the divisor.
  always_comb begin
    hi   = num_i[NumW-1:QuoW];
    ovf0 = (CmpW'(hi) >= CmpW'(div_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[0] <= '0;
    end else if (en_i) begin
      tag_q[0] <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q[0] <= {(ovf0 ? '0 : DivW'(hi)), num_i[QuoW-1:0]};
      div_q[0] <= div_i;
      ovf_q[0] <= ovf0;
    end
  end

  // One quotient bit per stage.
  for (genvar k = 1; k <= QuoW; k++) begin : g_stage
    logic [DivW:0]   shifted;
    logic [DivW+1:0] diff;
    logic            ge;

    always_comb begin
      shifted = {acc_q[k-1][AccW-1:QuoW], acc_q[k-1][QuoW-1]};
      diff    = (DivW+2)'(shifted) - (DivW+2)'(div_q[k-1]);
      ge      = !diff[DivW+1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k] <= '0;
      end else if (en_i) begin
        tag_q[k] <= tag_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[k] <= {(ge ? diff[DivW-1:0] : shifted[DivW-1:0]),
                     acc_q[k-1][QuoW-2:0], ge};
        div_q[k] <= div_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign tag_o = tag_q[QuoW];
  assign quo_o = acc_q[QuoW][QuoW-1:0];
  assign ovf_o = ovf_q[QuoW];

endmodule

@@ rtl/vrp_finish.sv @@
`timescale 1ns / 1ps
// ============================================================================
// vrp_finish
// Four stages: clamp and sign of the quotients, screen mapping of x and y,
// and depth saturation.
// ============================================================================
module vrp_finish #(
  parameter int ScreenWidth  = vrp_pkg::DefScreenWidth,
  parameter int ScreenHeight = vrp_pkg::DefScreenHeight
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  vrp_pkg::vrp_tag_t         tag_x_i,
  input  vrp_pkg::vrp_tag_t         tag_y_i,
  input  vrp_pkg::vrp_tag_t         tag_z_i,
  input  logic [vrp_pkg::QuoW-1:0]  quo_x_i,
  input  logic [vrp_pkg::QuoW-1:0]  quo_y_i,
  input  logic [vrp_pkg::QuoW-1:0]  quo_z_i,
  input  logic                      ovf_x_i,
  input  logic                      ovf_y_i,
  input  logic                      ovf_z_i,
  output logic                      valid_o,
  output vrp_pkg::vrp_result_t      res_o
);
  import vrp_pkg::*;

  localparam int MaxSize = (ScreenWidth > ScreenHeight) ? ScreenWidth : ScreenHeight;
  localparam int SW      = $clog2(MaxSize + 1);
  localparam int SumW    = QuoW + 1;
  localparam int TW      = SumW + SW + 1;
  localparam int ShW     = TW - PixShift;
  localparam int ProdW   = PixMW + Recip5W;

  logic [QuoW-1:0] mag [2];
  logic            ovf [2];
  logic            neg [2];
  logic [PixW-1:0] pix [2];

  logic [3:0]        valid_q;
  logic              last_q [4];
  logic              skip_q [4];
  logic [DepthW-1:0] dep_q [4];
  logic [DepthW-1:0] dep_d;

  assign mag[0] = quo_x_i;
  assign mag[1] = quo_y_i;
  assign ovf[0] = ovf_x_i;
  assign ovf[1] = ovf_y_i;
  assign neg[0] = tag_x_i.neg;
  assign neg[1] = tag_y_i.neg;

  // Screen mapping of one axis.
  for (genvar g = 0; g < 2; g++) begin : g_axis
    localparam int Size = (g == 0) ? ScreenWidth : ScreenHeight;
    localparam logic signed [SW:0] SizeS = (SW+1)'(Size);

    logic signed [QuoW-1:0] p_q;
    logic signed [TW-1:0]   t_q;
    logic [PixMW-1:0]       m_q;
    logic [PixW-1:0]        q_q;
    logic                   n3_q, n4_q;

    logic [QuoW-1:0]        cl;
    logic signed [SumW-1:0] sum;
    logic [TW-1:0]          tmag;
    logic [ShW-1:0]         sh;
    logic [ProdW-1:0]       prod;

    always_comb begin
      cl   = (ovf[g] || (mag[g] > PixClamp)) ? PixClamp : mag[g];
      sum  = SumW'(p_q) + SumW'(PixBias);
      tmag = t_q[TW-1] ? TW'(-t_q) : TW'(t_q);
      sh   = tmag[TW-1:PixShift];
      prod = ProdW'(m_q) * ProdW'(Recip5);
      // Truncate toward zero, then saturate.
      if (n4_q) begin
        pix[g] = (q_q > PixMin) ? PixMin : PixW'(~q_q + PixW'(1));
      end else begin
        pix[g] = (q_q > PixMax) ? PixMax : q_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        // Stage 1: signed, clamped projected value.
        p_q  <= neg[g] ? $signed(QuoW'(~cl + QuoW'(1))) : $signed(cl);
        // Stage 2: biased value times the screen size.
        t_q  <= TW'(sum) * TW'(SizeS);
        // Stage 3: magnitude over 2^18, capped where every size saturates.
        m_q  <= (sh >= ShW'(PixMagMax)) ? PixMW'(PixMagMax) : sh[PixMW-1:0];
        n3_q <= t_q[TW-1];
        // Stage 4: divide by five through the reciprocal.
        q_q  <= prod[ProdW-1:PixShift];
        n4_q <= n3_q;
      end
    end
  end

  // Depth saturation.
  always_comb begin
    if (tag_z_i.neg) begin
      dep_d = (ovf_z_i || (quo_z_i > DepthNegLim)) ? DepthMin
                                                  : DepthW'(~quo_z_i + QuoW'(1));
    end else begin
      dep_d = (ovf_z_i || (quo_z_i > DepthPosLim)) ? DepthMax : quo_z_i[DepthW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], tag_x_i.valid};
    end
  end

  // Depth and flags ride along with the screen stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dep_q[0]  <= dep_d;
      last_q[0] <= tag_x_i.last;
      skip_q[0] <= tag_x_i.skip;
      for (int i = 1; i < 4; i++) begin
        dep_q[i]  <= dep_q[i-1];
        last_q[i] <= last_q[i-1];
        skip_q[i] <= skip_q[i-1];
      end
    end
  end

  assign valid_o        = valid_q[3];
  assign res_o.last     = last_q[3];
  assign res_o.skip     = skip_q[3];
  assign res_o.depth    = dep_q[3];
  assign res_o.screen_x = pix[0];
  assign res_o.screen_y = pix[1];

endmodule

@@ rtl/vertex_rotate_project.sv @@
`timescale 1ns / 1ps
// ============================================================================
// vertex_rotate_project
// Rotates a Q8.16 vertex about Z and X, offsets z by 3.0, projects it with a
// divide by w and maps x and y to saturated screen pixels.
//
//   Channel   Direction  Handshake                   Payload
//   s_axis    in         s_axis_tvalid/tready        tdata, tlast
//   m_axis    out        m_axis_tvalid/tready        tdata, tuser, tlast
//   cfg       in         cfg_we_i (no back-pressure) cfg_idx_i, cfg_data_i
//
// One vertex is taken per clock while the output buffer has room. An input
// transfer passes the 4 rotation and 3 projection stages, the 43-stage divider
// (an entry stage, then one quotient bit per stage), the 4 screen-mapping
// stages and the output buffer before its result appears.
// Reset clears the registers to their default values and empties the pipe.
// A two-entry output buffer absorbs stalls; when it is full the whole pipe
// holds and s_axis_tready is low, so nothing is lost or repeated.
// ============================================================================
module vertex_rotate_project #(
  parameter int SCREEN_WIDTH  = vrp_pkg::DefScreenWidth,
  parameter int SCREEN_HEIGHT = vrp_pkg::DefScreenHeight
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input vertices.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,    // vertex_x, vertex_y, vertex_z
  input  logic        s_axis_tlast,    // last_of_triangle
  // Screen results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,    // screen_x, screen_y, depth
  output logic        m_axis_tuser,    // divide_skipped
  output logic        m_axis_tlast,    // triangle_done
  // Register writes.
  input  logic                            cfg_we_i,
  input  logic [vrp_pkg::RegIdxW-1:0]     cfg_idx_i,
  input  logic [vrp_pkg::CfgDataW-1:0]    cfg_data_i
);
  import vrp_pkg::*;

  vrp_cfg_t    cfg_q;
  vrp_ctrl_t   in_ctrl, rot_ctrl;
  logic        en;

  logic signed [X1W-1:0] x1;
  logic signed [Y2W-1:0] y2;
  logic signed [WW-1:0]  w;

  vrp_tag_t        ptag_x, ptag_y, ptag_z, dtag_x, dtag_y, dtag_z;
  logic [NumW-1:0] num_x, num_y, num_z;
  logic [DivW-1:0] div;
  logic [QuoW-1:0] quo_x, quo_y, quo_z;
  logic            ovf_x, ovf_y, ovf_z;

  logic        fin_valid;
  vrp_result_t fin_res;

  vrp_result_t buf_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic        push, pop;
  vrp_result_t head;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot_z_cos    <= TrigW'(16384);
      cfg_q.rot_z_sin    <= '0;
      cfg_q.rot_x_cos    <= TrigW'(16384);
      cfg_q.rot_x_sin    <= '0;
      cfg_q.proj_x_scale <= ScaleW'(61440);
      cfg_q.proj_y_scale <= ScaleW'(65536);
      cfg_q.depth_scale  <= ScaleW'(65543);
      cfg_q.depth_offset <= ScaleW'(-6554);
    end else if (cfg_we_i) begin
      unique case (vrp_reg_e'(cfg_idx_i))
        REG_ROT_Z_COS:    cfg_q.rot_z_cos    <= cfg_data_i[TrigW-1:0];
        REG_ROT_Z_SIN:    cfg_q.rot_z_sin    <= cfg_data_i[TrigW-1:0];
        REG_ROT_X_COS:    cfg_q.rot_x_cos    <= cfg_data_i[TrigW-1:0];
        REG_ROT_X_SIN:    cfg_q.rot_x_sin    <= cfg_data_i[TrigW-1:0];
        REG_PROJ_X_SCALE: cfg_q.proj_x_scale <= cfg_data_i;
        REG_PROJ_Y_SCALE: cfg_q.proj_y_scale <= cfg_data_i;
        REG_DEPTH_SCALE:  cfg_q.depth_scale  <= cfg_data_i;
        REG_DEPTH_OFFSET: cfg_q.depth_offset <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The pipe advances whenever the output buffer has room.
  assign en            = (count_q != 2'd2);
  assign s_axis_tready = en;
  assign in_ctrl       = '{valid: s_axis_tvalid, last: s_axis_tlast};

  vrp_rotate u_rotate (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .cfg_i  (cfg_q),
    .ctrl_i (in_ctrl),
    .vx_i   ($signed(s_axis_tdata[23:0])),
    .vy_i   ($signed(s_axis_tdata[47:24])),
    .vz_i   ($signed(s_axis_tdata[71:48])),
    .ctrl_o (rot_ctrl),
    .x1_o   (x1),
    .y2_o   (y2),
    .w_o    (w)
  );

  vrp_project u_project (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .ctrl_i  (rot_ctrl),
    .x1_i    (x1),
    .y2_i    (y2),
    .w_i     (w),
    .tag_x_o (ptag_x),
    .tag_y_o (ptag_y),
    .tag_z_o (ptag_z),
    .num_x_o (num_x),
    .num_y_o (num_y),
    .num_z_o (num_z),
    .div_o   (div)
  );

  vrp_div u_div_x (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .tag_i (ptag_x), .num_i (num_x), .div_i (div),
    .tag_o (dtag_x), .quo_o (quo_x), .ovf_o (ovf_x)
  );

  vrp_div u_div_y (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .tag_i (ptag_y), .num_i (num_y), .div_i (div),
    .tag_o (dtag_y), .quo_o (quo_y), .ovf_o (ovf_y)
  );

  vrp_div u_div_z (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .tag_i (ptag_z), .num_i (num_z), .div_i (div),
    .tag_o (dtag_z), .quo_o (quo_z), .ovf_o (ovf_z)
  );

  vrp_finish #(
    .ScreenWidth  (SCREEN_WIDTH),
    .ScreenHeight (SCREEN_HEIGHT)
  ) u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .tag_x_i (dtag_x),
    .tag_y_i (dtag_y),
    .tag_z_i (dtag_z),
    .quo_x_i (quo_x),
    .quo_y_i (quo_y),
    .quo_z_i (quo_z),
    .ovf_x_i (ovf_x),
    .ovf_y_i (ovf_y),
    .ovf_z_i (ovf_z),
    .valid_o (fin_valid),
    .res_o   (fin_res)
  );

  // Two-entry output buffer.
  assign push = en && fin_valid;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= fin_res;
    end
  end

  assign head          = buf_q[rd_ptr_q];
  assign m_axis_tvalid = (count_q != 2'd0);
  assign m_axis_tdata  = {head.depth, head.screen_y, head.screen_x};
  assign m_axis_tuser  = head.skip;
  assign m_axis_tlast  = head.last;

  // The buffer never holds more than two results.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2)
    else $error("output buffer count out of range");

  // A held pipe keeps its last-stage valid bit.
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(fin_valid))
    else $error("pipe moved while stalled");

  // A push without a pop grows the buffer by one.
  a_push_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 2'd1))
    else $error("buffer count did not follow a push");

endmodule

@@ sim/vertex_rotate_project_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// vertex_rotate_project_tb
// Streams vertices through the transform under several register settings and
// compares every screen result against a fixed-point predictor of the block.
// ============================================================================
module vertex_rotate_project_tb;
  import vrp_pkg::*;

  // Predicts screen results from accepted vertices and checks the output.
  class screen_scoreboard;
    longint regval[8];
    vrp_result_t pending_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function void report(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      errors++;
    endfunction

    function longint to_pixel(longint p, longint size);
      longint t;
      if (p > (longint'(1) << 40)) p = longint'(1) << 40;
      if (p < -(longint'(1) << 40)) p = -(longint'(1) << 40);
      t = ((p + 655360) * size) / 1310720;
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      return t;
    endfunction

    // Rotate, translate, project, divide and map one vertex.
    function void note_vertex(logic [23:0] vx, logic [23:0] vy, logic [23:0] vz,
                              logic last);
      longint x, y, z, x1, y1, y2, z2, px, py, pz;
      vrp_result_t r;
      x = $signed(vx);
      y = $signed(vy);
      z = $signed(vz);
      x1 = (x * regval[REG_ROT_Z_COS] - y * regval[REG_ROT_Z_SIN]) >>> 14;
      y1 = (x * regval[REG_ROT_Z_SIN] + y * regval[REG_ROT_Z_COS]) >>> 14;
      y2 = (y1 * regval[REG_ROT_X_COS] - z * regval[REG_ROT_X_SIN]) >>> 14;
      z2 = ((y1 * regval[REG_ROT_X_SIN] + z * regval[REG_ROT_X_COS]) >>> 14) + 196608;
      px = (x1 * regval[REG_PROJ_X_SCALE]) >>> 16;
      py = (y2 * regval[REG_PROJ_Y_SCALE]) >>> 16;
      pz = ((z2 * regval[REG_DEPTH_SCALE]) >>> 16) + regval[REG_DEPTH_OFFSET];
      r.skip = (z2 == 0);
      if (!r.skip) begin
        px = (px * 65536) / z2;
        py = (py * 65536) / z2;
        pz = (pz * 65536) / z2;
      end
      if (pz > 8388607) pz = 8388607;
      if (pz < -8388608) pz = -8388608;
      r.screen_x = PixW'(to_pixel(px, DefScreenWidth));
      r.screen_y = PixW'(to_pixel(py, DefScreenHeight));
      r.depth = DepthW'(pz);
      r.last = last;
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [55:0] data, logic user, logic last);
      vrp_result_t e;
      if (pending_q.size() == 0) begin
        report("unexpected result", data, 0);
        return;
      end
      e = pending_q.pop_front();
      if (data[15:0] !== e.screen_x)
        report("screen_x", $signed(data[15:0]), $signed(e.screen_x));
      if (data[31:16] !== e.screen_y)
        report("screen_y", $signed(data[31:16]), $signed(e.screen_y));
      if (data[55:32] !== e.depth)
        report("depth", $signed(data[55:32]), $signed(e.depth));
      if (user !== e.skip) report("divide_skipped", user, e.skip);
      if (last !== e.last) report("triangle_done", last, e.last);
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;    // vertex_x, vertex_y, vertex_z
  logic        s_axis_tlast = 1'b0;  // last_of_triangle
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;         // screen_x, screen_y, depth
  logic        m_axis_tuser;         // divide_skipped
  logic        m_axis_tlast;         // triangle_done
  logic                cfg_we_i = 1'b0;
  logic [RegIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  screen_scoreboard sb = new();
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  rx_hold_req = 0;
  longint cycles = 0;

  vertex_rotate_project uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Observe transfers on both sides.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_vertex(s_axis_tdata[23:0], s_axis_tdata[47:24], s_axis_tdata[71:48],
                       s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // Receiver: random stalls, or a long hold-off when requested.
  initial begin
    forever begin
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        rx_hold_req = 0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        @(posedge clk_i);
      end
    end
  end

  task automatic send_vertex(logic [23:0] x, logic [23:0] y, logic [23:0] z, logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x};
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Let a clock edge pass first so the last accepted vertex is already noted.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all eight registers; only called while the block is idle.
  task automatic load_regs(longint vals[8]);
    vrp_reg_e r;
    r = r.first();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= r;
      cfg_data_i <= CfgDataW'(vals[r]);
      sb.regval[r] = vals[r];
      @(posedge clk_i);
      r = r.next();
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(9))
      0: return 24'($urandom);
      1: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($signed($urandom_range(524288)) - 262144);
    endcase
  endfunction

  function automatic longint rand_trig();
    if ($urandom_range(3) == 0) return $signed(16'($urandom));
    return longint'($urandom_range(32768)) - 16384;
  endfunction

  function automatic longint rand_scale();
    if ($urandom_range(3) == 0) return $signed(24'($urandom));
    return longint'($urandom_range(262144)) - 65536;
  endfunction

  initial begin
    longint settings[8];
    int n;
    logic [23:0] z;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 7; ph++) begin
      // Idling pattern: sender light and receiver heavy, then swapped, then none.
      tx_idle_pct = (ph < 2) ? 7 : (ph < 4) ? 45 : 0;
      rx_idle_pct = (ph < 2) ? 45 : (ph < 4) ? 7 : 0;
      case (ph)
        0: settings = '{16384, 0, 16384, 0, 61440, 65536, 65543, -6554};
        1: settings = '{32767, 32767, 32767, 32767, 8388607, 8388607, 8388607, 8388607};
        2: settings = '{-32768, -32768, -32768, -32768, -8388608, -8388608, -8388608,
                        -8388608};
        3: settings = '{0, 16384, 11585, 11585, 61440, 65536, 65543, -6554};
        default: begin
          foreach (settings[i]) settings[i] = (i < 4) ? rand_trig() : rand_scale();
        end
      endcase
      load_regs(settings);

      // Directed corners: field extremes and a zero w with identity rotation.
      if (ph == 0 || ph == 1) begin
        send_vertex(24'h000000, 24'h000000, 24'h000000, 1'b0);
        send_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
        send_vertex(24'h800000, 24'h800000, 24'h800000, 1'b0);
        send_vertex(24'h7FFFFF, 24'h800000, 24'h000000, 1'b1);
        send_vertex(24'h800000, 24'h7FFFFF, 24'hFFFFFF, 1'b0);
        send_vertex(24'h000000, 24'h000000, -24'sd196608, 1'b1);
        send_vertex(24'h010000, 24'hFF0000, -24'sd196608, 1'b0);
        send_vertex(24'h7FFFFF, 24'h800000, -24'sd196608, 1'b1);
        send_vertex(24'h000001, 24'hFFFFFF, -24'sd196607, 1'b0);
        send_vertex(24'hFFFFFF, 24'h000001, -24'sd196609, 1'b1);
        send_vertex(24'h0A0000, 24'hF60000, 24'h000000, 1'b0);
        send_vertex(24'h555555, 24'hAAAAAA, 24'h555555, 1'b1);
      end

      // Random triangles.
      n = 180;
      for (int i = 0; i < n; i++) begin
        if (ph == 1 && i == 40) rx_hold_req = 1;
        if (ph == 2 && i == 90) drain();
        z = rand_coord();
        if (ph == 0 && $urandom_range(19) == 0) z = -24'sd196608;
        send_vertex(rand_coord(), rand_coord(), z, (i % 3) == 2);
      end
      drain();
    end

    repeat (80) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
